// ===== rtl/dva_pkg.sv =====
package dva_pkg;

  localparam int MAG_W      = 24;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int DSQ_W      = SQ_W + 2;
  localparam int DIST_W     = 20;
  localparam int DSQR_W     = 2 * DIST_W;
  localparam int RAD_W      = DIST_W + 1;
  localparam int RADSQ_W    = 2 * RAD_W;
  localparam int VOL_W      = 16;
  localparam int MODE_W     = 5;
  localparam int CFG_W      = 32;
  localparam int IDX_W      = 3;
  localparam int NUM_LANES  = 3;
  localparam int DIV_STEPS  = 16;
  localparam int LANE_LAT   = DIV_STEPS + 4;
  localparam int PIPE_DEPTH = LANE_LAT + 3;

  localparam logic [RAD_W-1:0]  ACTIVATION_MARGIN = RAD_W'(5120);
  localparam logic [DIST_W-1:0] DEFAULT_RADIUS    = DIST_W'(25600);
  localparam logic [VOL_W-1:0]  UNITY_VOLUME      = VOL_W'(32768);

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(17);
  localparam logic [CFG_W-1:0]  VOL_RESET  = CFG_W'(32'h4000_8000);
  localparam logic [DIST_W-1:0] NEAR_RESET = DIST_W'(7680);
  localparam logic [DIST_W-1:0] FAR_RESET  = DIST_W'(25600);

  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_VOLUME = 3'd1;
  localparam logic [IDX_W-1:0] REG_NEAR_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_NEAR_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_NEAR_Z = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAR_X  = 3'd5;
  localparam logic [IDX_W-1:0] REG_FAR_Y  = 3'd6;
  localparam logic [IDX_W-1:0] REG_FAR_Z  = 3'd7;

  typedef struct packed {
    logic [DSQR_W-1:0] dnsq;
    logic [DSQR_W-1:0] dfsq;
    logic [DSQR_W-1:0] dden;
    logic [VOL_W-1:0]  vn;
    logic [VOL_W-1:0]  vf;
  } lane_cfg_t;

  // one restoring step: {next remainder, quotient bit}
  function automatic logic [DSQR_W:0] div_step(input logic [DSQR_W-1:0] rem,
                                               input logic [DSQR_W-1:0] den);
    logic [DSQR_W:0] sh;
    logic [DSQR_W:0] dif;
    sh  = {rem, 1'b0};
    dif = sh - {1'b0, den};
    if (sh >= {1'b0, den}) begin
      return {dif[DSQR_W-1:0], 1'b1};
    end
    return {sh[DSQR_W-1:0], 1'b0};
  endfunction

endpackage

// ===== rtl/distance_volume_attenuator.sv =====
// Throughput: one word per cycle while the output is not stalled; 16 one-bit divider stages per lane set the depth.
// Words outside the activation radius, or with sound disabled, yield no result.
// A stalled output holds the whole pipeline.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module distance_volume_attenuator
  import dva_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [MAG_W-1:0] in_rel_x,
  input  logic signed [MAG_W-1:0] in_rel_y,
  input  logic signed [MAG_W-1:0] in_rel_z,
  input  logic signed [MAG_W-1:0] in_proj_x,
  input  logic signed [MAG_W-1:0] in_proj_y,
  input  logic signed [MAG_W-1:0] in_proj_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [VOL_W-1:0]        out_volume_factor,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  logic [MODE_W-1:0]  mode_r;
  logic [CFG_W-1:0]   vol_r;
  logic [DIST_W-1:0]  near_r [NUM_LANES];
  logic [DIST_W-1:0]  far_r  [NUM_LANES];

  logic [DIST_W-1:0]  dn_r   [NUM_LANES];
  logic [DSQR_W-1:0]  dnsq_r [NUM_LANES];
  logic [DSQR_W-1:0]  dfsq_r [NUM_LANES];
  logic [DSQR_W-1:0]  dden_r [NUM_LANES];
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [RADSQ_W-1:0] radsq_r;
  logic [DIST_W-1:0]  rmax;

  logic               spheric, adv;
  logic [MAG_W-1:0]   in_raw [6];
  logic [MAG_W-1:0]   mag_r  [6];
  logic [SQ_W-1:0]    sq_r   [6];
  logic [DSQ_W-1:0]   dsq;
  logic [DSQ_W-1:0]   d2_r   [NUM_LANES];
  logic               vld_r  [PIPE_DEPTH];
  lane_cfg_t          lcfg   [NUM_LANES];
  logic [VOL_W-1:0]   lane_res [NUM_LANES];
  logic [VOL_W-1:0]   factor;
  logic               out_valid_r;
  logic [VOL_W-1:0]   out_factor_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign spheric  = mode_r[0] || (mode_r[3:1] == 3'b000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      vol_r  <= VOL_RESET;
      for (int a = 0; a < NUM_LANES; a++) begin
        near_r[a] <= NEAR_RESET;
        far_r[a]  <= FAR_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode_r    <= cfg_data[MODE_W-1:0];
        REG_VOLUME: vol_r     <= cfg_data;
        REG_NEAR_X: near_r[0] <= cfg_data[DIST_W-1:0];
        REG_NEAR_Y: near_r[1] <= cfg_data[DIST_W-1:0];
        REG_NEAR_Z: near_r[2] <= cfg_data[DIST_W-1:0];
        REG_FAR_X:  far_r[0]  <= cfg_data[DIST_W-1:0];
        REG_FAR_Y:  far_r[1]  <= cfg_data[DIST_W-1:0];
        REG_FAR_Z:  far_r[2]  <= cfg_data[DIST_W-1:0];
        default:    mode_r    <= mode_r;
      endcase
    end
  end

  always_comb begin
    rmax = '0;
    for (int a = 0; a < NUM_LANES; a++) begin
      if (mode_r[a+1] && far_r[a] > rmax) begin
        rmax = far_r[a];
      end
    end
    if (mode_r[3:0] == 4'd1) begin
      rmax = far_r[0];
    end else if (spheric) begin
      rmax = DEFAULT_RADIUS;
    end
    rad_nxt = {1'b0, rmax} + ACTIVATION_MARGIN;
  end

  // derived from configuration through chained registers; not held by a stall
  always_ff @(posedge clk) begin
    rad_r   <= rad_nxt;
    radsq_r <= rad_r * rad_r;
    for (int a = 0; a < NUM_LANES; a++) begin
      dn_r[a]   <= (near_r[a] < far_r[a]) ? near_r[a] : far_r[a];
      dnsq_r[a] <= dn_r[a] * dn_r[a];
      dfsq_r[a] <= far_r[a] * far_r[a];
      dden_r[a] <= dfsq_r[a] - dnsq_r[a];
    end
  end

  assign in_raw[0] = in_rel_x;
  assign in_raw[1] = in_rel_y;
  assign in_raw[2] = in_rel_z;
  assign in_raw[3] = in_proj_x;
  assign in_raw[4] = in_proj_y;
  assign in_raw[5] = in_proj_z;

  assign dsq = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        mag_r[i] <= in_raw[i][MAG_W-1] ? (~in_raw[i] + 1'b1) : in_raw[i];
        sq_r[i]  <= mag_r[i] * mag_r[i];
      end
      d2_r[0] <= spheric ? dsq : {2'b00, sq_r[3]};
      d2_r[1] <= {2'b00, sq_r[4]};
      d2_r[2] <= {2'b00, sq_r[5]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid && mode_r[4];
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1] && (dsq <= {{(DSQ_W-RADSQ_W){1'b0}}, radsq_r});
      for (int k = 3; k < PIPE_DEPTH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lcfg[g].dnsq = dnsq_r[g];
    assign lcfg[g].dfsq = dfsq_r[g];
    assign lcfg[g].dden = dden_r[g];
    assign lcfg[g].vn   = vol_r[CFG_W-1:VOL_W];
    assign lcfg[g].vf   = vol_r[VOL_W-1:0];

    dva_lane u_lane (
      .clk (clk),
      .adv (adv),
      .d2  (d2_r[g]),
      .cfg (lcfg[g]),
      .res (lane_res[g])
    );
  end

  dva_merge u_merge (
    .mode     (mode_r),
    .lane_res (lane_res),
    .factor   (factor)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_factor_r <= factor;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_volume_factor = out_factor_r;

endmodule

// ===== rtl/dva_lane.sv =====
module dva_lane
  import dva_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  logic [DSQ_W-1:0] d2,
  input  lane_cfg_t        cfg,
  output logic [VOL_W-1:0] res
);

  logic              le_c_r, ge_c_r;
  logic [DSQR_W-1:0] xr_c_r, xs_c_r, dr_c_r;

  logic [DSQR_W-1:0] rr_r [DIV_STEPS];
  logic [DSQR_W-1:0] rs_r [DIV_STEPS];
  logic [DSQR_W-1:0] dd_r [DIV_STEPS];
  logic [VOL_W-1:0]  qr_r [DIV_STEPS];
  logic [VOL_W-1:0]  qs_r [DIV_STEPS];
  logic [1:0]        fl_r [DIV_STEPS];

  logic [VOL_W-1:0]  t_r, delta_r, res_r;
  logic [1:0]        fl1_r, fl2_r;
  logic [2*VOL_W-1:0] prod_t, prod_d;
  logic [VOL_W-1:0]  vdiff;

  always_ff @(posedge clk) begin
    if (adv) begin
      le_c_r <= d2 <= {{(DSQ_W-DSQR_W){1'b0}}, cfg.dnsq};
      ge_c_r <= d2 >= {{(DSQ_W-DSQR_W){1'b0}}, cfg.dfsq};
      xr_c_r <= cfg.dnsq;
      xs_c_r <= cfg.dfsq - d2[DSQR_W-1:0];
      dr_c_r <= d2[DSQR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    logic [DSQR_W:0]  sr, ss;
    logic [DSQR_W-1:0] pr, ps, pd;
    logic [VOL_W-1:0]  pqr, pqs;
    logic [1:0]        pf;
    if (adv) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (k == 0) begin
          pr = xr_c_r; ps = xs_c_r; pd = dr_c_r;
          pqr = '0; pqs = '0; pf = {ge_c_r, le_c_r};
        end else begin
          pr = rr_r[k-1]; ps = rs_r[k-1]; pd = dd_r[k-1];
          pqr = qr_r[k-1]; pqs = qs_r[k-1]; pf = fl_r[k-1];
        end
        sr = div_step(pr, pd);
        ss = div_step(ps, cfg.dden);
        rr_r[k] <= sr[DSQR_W:1];
        rs_r[k] <= ss[DSQR_W:1];
        dd_r[k] <= pd;
        qr_r[k] <= {pqr[VOL_W-2:0], sr[0]};
        qs_r[k] <= {pqs[VOL_W-2:0], ss[0]};
        fl_r[k] <= pf;
      end
    end
  end

  assign prod_t = qr_r[DIV_STEPS-1] * qs_r[DIV_STEPS-1];
  assign vdiff  = (cfg.vn >= cfg.vf) ? (cfg.vn - cfg.vf) : (cfg.vf - cfg.vn);
  assign prod_d = vdiff * t_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r     <= prod_t[2*VOL_W-1:VOL_W];
      fl1_r   <= fl_r[DIV_STEPS-1];
      delta_r <= prod_d[2*VOL_W-1:VOL_W];
      fl2_r   <= fl1_r;
      if (fl2_r[0]) begin
        res_r <= cfg.vn;
      end else if (fl2_r[1]) begin
        res_r <= cfg.vf;
      end else if (cfg.vn >= cfg.vf) begin
        res_r <= cfg.vf + delta_r;
      end else begin
        res_r <= cfg.vf - delta_r;
      end
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/dva_merge.sv =====
module dva_merge
  import dva_pkg::*;
(
  input  logic [MODE_W-1:0] mode,
  input  logic [VOL_W-1:0]  lane_res [NUM_LANES],
  output logic [VOL_W-1:0]  factor
);

  logic             spheric;
  logic [VOL_W-1:0] mx;

  assign spheric = mode[0] || (mode[3:1] == 3'b000);

  always_comb begin
    mx = '0;
    for (int a = 0; a < NUM_LANES; a++) begin
      if (mode[a+1] && lane_res[a] > mx) begin
        mx = lane_res[a];
      end
    end
    if (mx > UNITY_VOLUME) begin
      mx = UNITY_VOLUME;
    end
    factor = spheric ? lane_res[0] : mx;
  end

endmodule
